// ----- rtl/lnu_pkg.sv -----
package lnu_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int CNT_W        = $clog2(MAX_FEATURES + 1);
    localparam int ADDR_W       = $clog2(MAX_FEATURES);
    localparam int SUM_W        = 16 + ADDR_W + 1;
    localparam int ACC_W        = 33 + ADDR_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_NUM_W    = 57;
    localparam int DIV_DEN_W    = 34;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);
    localparam int ROOT_W       = 29;
    localparam int SQRT_CNT_W   = $clog2(ROOT_W);

    localparam int CFG_W        = 24;
    localparam int ROW_W        = 48;

    localparam logic [ROOT_W-1:0]    INV_LIMIT   = ROOT_W'(1) << 28;
    localparam logic [DIV_NUM_W-1:0] ONE_Q56     = DIV_NUM_W'(1) << 56;
    localparam logic [CFG_W-1:0]     EPSILON_RST = CFG_W'(168);

    // configuration register indexes
    localparam logic REG_EPSILON     = 1'b0;
    localparam logic REG_BIAS_ENABLE = 1'b1;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] weight;
        logic signed [15:0] bias;
        logic               last_element;
    } item_t;

    typedef struct packed {
        logic signed [15:0] y_value;
        logic               last_result;
        logic               row_overflow;
    } result_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_W,
        S_VAR_RD,
        S_VAR_SQ,
        S_VAR_ADD,
        S_VDIV,
        S_VDIV_W,
        S_LDIV,
        S_LDIV_W,
        S_SQRT,
        S_SQRT_W,
        S_OUT_RD,
        S_OUT_M1,
        S_OUT_M2,
        S_OUT_FIN
    } state_t;

endpackage

// ----- rtl/lnu_ram.sv -----
module lnu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/lnu_front.sv -----
module lnu_front
    import lnu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign item_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (cnt_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/lnu_div.sv -----
module lnu_div
    import lnu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    // restoring divider, one quotient bit per cycle
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ----- rtl/lnu_isqrt.sv -----
module lnu_isqrt
    import lnu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] value,
    output logic                 done,
    output logic [ROOT_W-1:0]    root
);

    // digit-by-digit square root, two radicand bits per cycle
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W+1:0]      shifted;
    logic [REM_W+1:0]      trial;
    logic                  fits;

    assign shifted = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = (shifted >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RAD_W'(value);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? REM_W'(shifted - trial) : REM_W'(shifted);
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg + SQRT_CNT_W'(1);
            if (cnt_reg == SQRT_CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/lnu_back.sv -----
module lnu_back
    import lnu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     ovf_reg, ovf_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic signed [15:0]       mean_reg, mean_next;
    logic                     neg_reg, neg_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [31:0]              sq_reg, sq_next;
    logic [DIV_DEN_W-1:0]     var_reg, var_next;
    logic [ROOT_W-1:0]        inv_reg, inv_next;
    logic signed [46:0]       p1_reg, p1_next;
    logic signed [62:0]       p2_reg, p2_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;
    logic [CFG_W-1:0]         eps_reg;
    logic                     bias_en_reg;

    logic                     ram_we;
    logic [ROW_W-1:0]         ram_rd;
    logic signed [15:0]       rx, rw, rb;
    logic signed [16:0]       d;
    logic signed [33:0]       sq_full;
    logic signed [34:0]       ysh;
    logic signed [35:0]       ysum;
    logic signed [15:0]       ysat;
    logic [SUM_W-1:0]         sum_abs;
    logic                     last_idx;
    logic                     out_free;
    logic                     store_ok;

    logic                     div_start, div_busy, div_done;
    logic [DIV_NUM_W-1:0]     div_num, div_quo;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;

    localparam logic signed [35:0] Y_MAX = 36'sd32767;
    localparam logic signed [35:0] Y_MIN = -36'sd32768;

    lnu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_FEATURES)
    ) u_row_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data ({q_item.x_value, q_item.weight, q_item.bias}),
        .rd_addr (idx_reg),
        .rd_data (ram_rd)
    );

    lnu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    lnu_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (div_quo),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign rx       = ram_rd[47:32];
    assign rw       = ram_rd[31:16];
    assign rb       = ram_rd[15:0];
    assign d        = 17'(rx) - 17'(mean_reg);
    assign sq_full  = d * d;
    assign ysh      = p2_reg[62:28];
    assign ysum     = 36'(ysh) + (bias_en_reg ? 36'(rb) : 36'sd0);
    assign ysat     = (ysum > Y_MAX) ? 16'sh7fff :
                      (ysum < Y_MIN) ? 16'sh8000 : ysum[15:0];
    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign last_idx = (CNT_W'(idx_reg) == cnt_reg - CNT_W'(1));
    assign out_free = !out_valid_reg || !result_stall;
    assign store_ok = (cnt_reg < CNT_W'(MAX_FEATURES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:    if (q_valid && q_item.last_element) state_next = S_MEAN;
            S_MEAN:    state_next = S_MEAN_W;
            S_MEAN_W:  if (div_done) state_next = S_VAR_RD;
            S_VAR_RD:  state_next = S_VAR_SQ;
            S_VAR_SQ:  state_next = S_VAR_ADD;
            S_VAR_ADD: state_next = last_idx ? S_VDIV : S_VAR_RD;
            S_VDIV:    state_next = S_VDIV_W;
            S_VDIV_W:  if (div_done) state_next = S_LDIV;
            S_LDIV:    state_next = (var_reg == '0) ? S_OUT_RD : S_LDIV_W;
            S_LDIV_W:  if (div_done) state_next = S_SQRT;
            S_SQRT:    state_next = S_SQRT_W;
            S_SQRT_W:  if (sqrt_done) state_next = S_OUT_RD;
            S_OUT_RD:  state_next = S_OUT_M1;
            S_OUT_M1:  state_next = S_OUT_M2;
            S_OUT_M2:  state_next = S_OUT_FIN;
            S_OUT_FIN:
            begin
                if (out_free)
                begin
                    state_next = last_idx ? S_LOAD : S_OUT_RD;
                end
            end
            default:   state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        mean_next      = mean_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        var_next       = var_reg;
        inv_next       = inv_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = DIV_DEN_W'(cnt_reg);
        sqrt_start     = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    if (store_ok)
                    begin
                        ram_we   = 1'b1;
                        sum_next = sum_reg + SUM_W'(q_item.x_value);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_MEAN:
            begin
                // floor division: bias a negative sum by n-1 before dividing
                div_start = 1'b1;
                div_num   = sum_reg[SUM_W-1]
                          ? DIV_NUM_W'(sum_abs) + DIV_NUM_W'(cnt_reg) - DIV_NUM_W'(1)
                          : DIV_NUM_W'(sum_abs);
                neg_next  = sum_reg[SUM_W-1];
                acc_next  = '0;
                idx_next  = '0;
            end
            S_MEAN_W:
            begin
                if (div_done)
                begin
                    mean_next = neg_reg ? -16'(div_quo) : 16'(div_quo);
                end
            end
            S_VAR_SQ:
            begin
                sq_next = sq_full[31:0];
            end
            S_VAR_ADD:
            begin
                acc_next = acc_reg + ACC_W'(sq_reg);
                idx_next = idx_reg + ADDR_W'(1);
            end
            S_VDIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(acc_reg);
                idx_next  = '0;
            end
            S_VDIV_W:
            begin
                if (div_done)
                begin
                    var_next = DIV_DEN_W'(div_quo) + DIV_DEN_W'(eps_reg);
                end
            end
            S_LDIV:
            begin
                div_den = var_reg;
                div_num = ONE_Q56;
                if (var_reg == '0)
                begin
                    inv_next = INV_LIMIT;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            S_SQRT:
            begin
                sqrt_start = 1'b1;
            end
            S_SQRT_W:
            begin
                if (sqrt_done)
                begin
                    inv_next = sqrt_root;
                end
            end
            S_OUT_M1:
            begin
                p1_next = d * $signed({1'b0, inv_reg});
            end
            S_OUT_M2:
            begin
                p2_next = p1_reg * rw;
            end
            S_OUT_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.y_value      = ysat;
                    out_next.last_result  = last_idx;
                    out_next.row_overflow = ovf_reg;
                    idx_next              = idx_reg + ADDR_W'(1);
                    if (last_idx)
                    begin
                        cnt_next = '0;
                        sum_next = '0;
                        ovf_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        var_reg  <= var_next;
        inv_reg  <= inv_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            eps_reg       <= EPSILON_RST;
            bias_en_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EPSILON:     eps_reg     <= cfg_data;
                    REG_BIAS_ENABLE: bias_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FEATURES))
        else $error("element count above capacity");

    a_pop_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_LOAD)
        else $error("queue popped outside load phase");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_row_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_FIN && out_free && last_idx) |=> (cnt_reg == '0 && !ovf_reg))
        else $error("row state not cleared after last result");

endmodule

// ----- rtl/layer_normalization_unit.sv -----
// Operation: a row loads at one transaction per cycle while the back end is in its load
//   state, then runs mean, variance and reciprocal on one 57-step divider and a 29-step
//   root (zero variance plus zero epsilon skips the reciprocal and the root).
// Results: one at a time, each read, scaled, weighted and registered; result_stall holds
//   the output. Reset: rst_n is asynchronous, active low; it empties the queue,
//   clears the row counters and restores epsilon = 168, bias_enable = 1. RAM is not cleared.
module layer_normalization_unit
    import lnu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // input transactions
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    // result transactions
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    // configuration write port
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Front end: a short queue absorbs incoming transactions so the
    // upstream side keeps moving while the back end is busy, until the queue is full.
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    lnu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back end: buffers the row in RAM, accumulates the sum, then runs
    // mean -> variance -> 2^56/var -> sqrt, and streams the scaled results
    // through an output register that decouples the downstream stall.
    lnu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

// ----- bench/tb_layer_normalization_unit.sv -----
module tb_layer_normalization_unit;
    import lnu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Slowest row: a full store of elements through the divider and root, then one result
    // at a time, stretched by receiver stalls. Settle time covers the compute of one full row.
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int PHASE_ITEMS   = 16;

    localparam longint INV_CAP = 64'sd1 << 28;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    layer_normalization_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Idle modes: none, sender idles half the time, receiver stalls half the
    // time, both idle at a low rate.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    idle_mode_t idle_mode;
    bit         hold_request;
    int         hold_left;
    int         cycle_count;
    bit         failed;

    // Mirror of the block's row state and configuration.
    logic [23:0]        norm_epsilon;
    logic               norm_bias_on;
    logic signed [15:0] row_x     [MAX_FEATURES];
    logic signed [15:0] row_w     [MAX_FEATURES];
    logic signed [15:0] row_b     [MAX_FEATURES];
    bit                 row_typed [MAX_FEATURES];
    logic signed [15:0] row_typed_y [MAX_FEATURES];
    longint             row_total;
    int                 row_len;
    bit                 row_dropped;

    result_t pending_results [$];

    // Directed table: typed y is used only where it is obvious, e.g. a row of
    // equal elements normalizes to zero and leaves only the bias.
    typedef struct {
        item_t              it;
        bit                 typed;
        logic signed [15:0] y;
    } table_row_t;

    localparam int TABLE_LEN = 16;
    table_row_t directed_table [TABLE_LEN] = '{
        // constant row at the positive extreme: output is the bias
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0}, 1'b1, 16'sh8000},
        '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF},
        // single-element row
        '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF},
        // extremes mixed: saturates both ways
        '{'{16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1}, 1'b0, 16'sh0000},
        // ordinary small values
        '{'{16'sh1000, 16'sh1000, 16'sh0000, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'shF000, 16'sh1000, 16'sh0064, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh0000, 16'shF000, 16'shFF9C, 1'b1}, 1'b0, 16'sh0000},
        // row held open across several transactions, negative mean
        '{'{16'sh0001, 16'sh0001, 16'sh0001, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh0002, 16'sh0002, 16'sh0002, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'sh0003, 16'sh0003, 16'sh0003, 1'b0}, 1'b0, 16'sh0000},
        '{'{16'shFFF0, 16'sh5555, 16'shAAAA, 1'b1}, 1'b0, 16'sh0000},
        // constant row of zeros, zero weight
        '{'{16'sh0000, 16'sh0000, 16'sh1234, 1'b0}, 1'b1, 16'sh1234},
        '{'{16'sh0000, 16'sh0000, 16'shEDCC, 1'b1}, 1'b1, 16'shEDCC}
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // floor(2^28 / sqrt(v)) as the largest r with r*r <= 2^56 / v, capped at 2^28
    function automatic longint inverse_root(longint unsigned v);
        longint unsigned bound;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (v == 0)
            return INV_CAP;
        bound = (64'd1 << 56) / v;
        lo = 0;
        hi = INV_CAP;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    // Absorb one accepted transaction; on row close, queue one result per
    // stored element in arrival order.
    task automatic absorb_element(item_t it, bit typed, logic signed [15:0] typed_y);
        longint mean;
        longint diff;
        longint unsigned sq_sum;
        longint inv;
        longint prod;
        longint y;
        result_t r;
        if (row_len < MAX_FEATURES)
        begin
            row_x[row_len]       = it.x_value;
            row_w[row_len]       = it.weight;
            row_b[row_len]       = it.bias;
            row_typed[row_len]   = typed;
            row_typed_y[row_len] = typed_y;
            row_total += longint'(it.x_value);
            row_len++;
        end
        else
            row_dropped = 1'b1;
        if (!it.last_element)
            return;

        if (row_total >= 0)
            mean = row_total / row_len;
        else
            mean = -((-row_total + row_len - 1) / row_len);
        sq_sum = 0;
        for (int i = 0; i < row_len; i++)
        begin
            diff = longint'(row_x[i]) - mean;
            sq_sum += longint'(diff * diff);
        end
        inv = inverse_root(sq_sum / row_len + norm_epsilon);

        for (int i = 0; i < row_len; i++)
        begin
            diff = longint'(row_x[i]) - mean;
            prod = diff * inv * longint'(row_w[i]);
            if (prod >= 0)
                y = prod >>> 28;
            else
                y = -((-prod + INV_CAP - 1) >>> 28);
            if (norm_bias_on)
                y += longint'(row_b[i]);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            r.y_value      = row_typed[i] ? row_typed_y[i] : 16'(y);
            r.last_result  = (i == row_len - 1);
            r.row_overflow = row_dropped;
            pending_results.push_back(r);
        end
        row_total   = 0;
        row_len     = 0;
        row_dropped = 1'b0;
    endtask

    task automatic offer_element(item_t it, bit typed, logic signed [15:0] typed_y);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 50 : (idle_mode == IDLE_BOTH) ? 8 : 0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        absorb_element(it, typed, typed_y);
    endtask

    task automatic write_register(logic index, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_EPSILON)
            norm_epsilon = value;
        else
            norm_bias_on = value[0];
        @(posedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One row: mostly short rows of random content, some constant (zero
    // variance), some with a narrow spread, a few longer than the store.
    task automatic send_row(int kind, int len);
        item_t it;
        logic signed [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            it.weight = 16'($urandom);
            it.bias   = 16'($urandom);
            case (kind)
                0:       it.x_value = 16'($urandom);
                1:       it.x_value = base;
                default: it.x_value = base + 16'($urandom_range(7)) - 16'sd4;
            endcase
            it.last_element = (i == len - 1);
            offer_element(it, 1'b0, 16'sd0);
        end
    endtask

    always @(posedge clk)
    begin
        int stall_pct;
        result_t want;
        if (hold_request && hold_left == 0)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;

        stall_pct = (idle_mode == IDLE_RECV) ? 50 : (idle_mode == IDLE_BOTH) ? 8 : 0;
        result_stall <= (hold_left > 1) || (hold_request && hold_left == 0)
                        || ($urandom_range(99) < stall_pct);

        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction y_value=%0d", result.y_value);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.y_value !== want.y_value)
                begin
                    $error("y_value: expected %0d, actual %0d", want.y_value, result.y_value);
                    failed = 1'b1;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0b, actual %0b",
                           want.last_result, result.last_result);
                    failed = 1'b1;
                end
                if (result.row_overflow !== want.row_overflow)
                begin
                    $error("row_overflow: expected %0b, actual %0b",
                           want.row_overflow, result.row_overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        logic [23:0] phase_eps  [6];
        logic        phase_bias [6];
        idle_mode_t  phase_mode [6];
        int          sent;
        int          len;
        int          kind;

        phase_eps  = '{24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd4096, 24'd168};
        phase_bias = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_NONE};
        phase_eps[4] = 24'($urandom);

        failed       = 1'b0;
        cycle_count  = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        idle_mode    = IDLE_NONE;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_EPSILON;
        cfg_data     = '0;
        norm_epsilon = EPSILON_RST;
        norm_bias_on = 1'b1;
        row_total    = 0;
        row_len      = 0;
        row_dropped  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings
        foreach (directed_table[i])
            offer_element(directed_table[i].it, directed_table[i].typed, directed_table[i].y);
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            write_register(REG_EPSILON, phase_eps[p]);
            write_register(REG_BIAS_ENABLE, CFG_W'(phase_bias[p]));
            idle_mode = phase_mode[p];
            // long receiver hold while the sender keeps pushing: fills the block
            if (p == 5)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                kind = $urandom_range(9);
                len  = $urandom_range(1, 8);
                // one over-long row in the overflow phases
                if ((p == 2 || p == 4) && sent == 0)
                    len = $urandom_range(MAX_FEATURES + 1, MAX_FEATURES + 4);
                send_row(kind < 6 ? 0 : kind < 8 ? 1 : 2, len);
                sent += len;
            end
            drain_results();
        end

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
